// File: sv/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg
// Shared types and constants for the PEEP limit alarm block.
// ----------------------------------------------------------------------------
`default_nettype none

package pla_pkg;

	localparam int unsigned PhaseW    = 2;
	localparam int unsigned SeqW      = 16;
	localparam int unsigned PressW    = 16;
	localparam int unsigned TimeW     = 32;
	localparam int unsigned OffsetW   = 13;
	localparam int unsigned RecTimeW  = 16;
	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned CfgDataW  = 16;
	// limit = set +/- offset is held with two more bits than a pressure
	localparam int unsigned LimitW    = PressW + 2;

	localparam logic [OffsetW-1:0]  HighOffsetReset   = OffsetW'(500);
	localparam logic [OffsetW-1:0]  LowOffsetReset    = OffsetW'(300);
	localparam logic [RecTimeW-1:0] RecoveryTimeReset = RecTimeW'(5000);

	typedef enum logic [CfgIndexW-1:0] {
		REG_HIGH_OFFSET   = 2'd0,
		REG_LOW_OFFSET    = 2'd1,
		REG_RECOVERY_TIME = 2'd2
	} reg_index_t;

	typedef enum logic [PhaseW-1:0] {
		PHASE_OTHER  = 2'd0,
		PHASE_INHALE = 2'd1,
		PHASE_EXHALE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [PhaseW-1:0]        phase;
		logic                     plan_valid;
		logic                     result_complete;
		logic [SeqW-1:0]          plan_sequence;
		logic [SeqW-1:0]          result_sequence;
		logic signed [PressW-1:0] measured_peep;
		logic signed [PressW-1:0] set_peep;
		logic [TimeW-1:0]         now_ms;
	} snapshot_t;

	typedef struct packed {
		logic high_alarm;
		logic low_alarm;
	} alarm_t;

	// per-detector settings
	typedef struct packed {
		logic [OffsetW-1:0]  offset;
		logic [RecTimeW-1:0] recovery_time;
	} det_cfg_t;

endpackage

`default_nettype wire

// File: sv/pla_if.sv
// ----------------------------------------------------------------------------
// pla_snap_if / pla_alarm_if
// Valid/ready channels for snapshot words in and alarm words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pla_snap_if import pla_pkg::*; ();
	logic      valid;
	logic      ready;
	snapshot_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface pla_alarm_if import pla_pkg::*; ();
	logic   valid;
	logic   ready;
	alarm_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/pla_detector.sv
// ----------------------------------------------------------------------------
// pla_detector
// One PEEP limit detector (high or low side) with its recovery timer state.
// ----------------------------------------------------------------------------
`default_nettype none

module pla_detector import pla_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      high_side,   // 1: PEEP too high, 0: PEEP too low
	input  wire logic      advance,     // snapshot in stage 1 is consumed
	input  wire snapshot_t snap,
	input  wire det_cfg_t  cfg,
	output logic           alarm        // alarm state after this snapshot
);

	logic             active_q, timing_q, seen_q;
	logic [SeqW-1:0]  last_seq_q;
	logic [TimeW-1:0] start_q;

	logic             active_d, timing_d, seen_d;
	logic [SeqW-1:0]  last_seq_d;
	logic [TimeW-1:0] start_d;

	logic signed [LimitW-1:0] meas_ext, set_ext, off_ext, limit;
	logic                     above, below, exceed, recovered;
	logic                     in_phase, data_ok, check;
	logic                     act_chk, tim_chk;
	logic [TimeW-1:0]         elapsed;

	always_comb begin
		meas_ext  = LimitW'(snap.measured_peep);
		set_ext   = LimitW'(snap.set_peep);
		off_ext   = $signed({{(LimitW-OffsetW){1'b0}}, cfg.offset});
		limit     = high_side ? (set_ext + off_ext) : (set_ext - off_ext);
		above     = meas_ext > limit;
		below     = meas_ext < limit;
		exceed    = high_side ? above : below;
		recovered = high_side ? below : above;
		elapsed   = snap.now_ms - start_q;

		in_phase  = (snap.phase == PHASE_INHALE) || (snap.phase == PHASE_EXHALE);
		data_ok   = snap.plan_valid && snap.result_complete;
		// one check per new plan sequence, inspiration only
		check     = (snap.phase == PHASE_INHALE) &&
		            (snap.result_sequence != snap.plan_sequence) &&
		            (!seen_q || (last_seq_q != snap.plan_sequence));
		act_chk   = active_q || (check && exceed);
		tim_chk   = timing_q && !(check && exceed);
	end

	always_comb begin
		active_d   = active_q;
		timing_d   = timing_q;
		seen_d     = seen_q;
		last_seq_d = last_seq_q;
		start_d    = start_q;
		if (!in_phase) begin
			active_d   = 1'b0;
			timing_d   = 1'b0;
			seen_d     = 1'b0;
			last_seq_d = '0;
			start_d    = '0;
		end else if (!data_ok) begin
			timing_d = 1'b0;
		end else begin
			if (check) begin
				last_seq_d = snap.plan_sequence;
				seen_d     = 1'b1;
			end
			active_d = act_chk;
			if (!act_chk || !recovered) begin
				timing_d = 1'b0;
			end else if (!tim_chk) begin
				start_d  = snap.now_ms;
				timing_d = 1'b1;
			end else if (elapsed >= TimeW'(cfg.recovery_time)) begin
				active_d = 1'b0;
				timing_d = 1'b0;
			end
		end
	end

	assign alarm = active_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			timing_q   <= 1'b0;
			seen_q     <= 1'b0;
			last_seq_q <= '0;
			start_q    <= '0;
		end else if (advance) begin
			active_q   <= active_d;
			timing_q   <= timing_d;
			seen_q     <= seen_d;
			last_seq_q <= last_seq_d;
			start_q    <= start_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/peep_limit_alarm.sv
// ----------------------------------------------------------------------------
// peep_limit_alarm
// PEEP too high / too low alarm detectors over a stream of ventilator snapshots.
// ----------------------------------------------------------------------------
// Path: snapshot accept to alarm word valid goes through the input register,
//   then the result register, held longer only while the alarm side stalls.
// Throughput: one snapshot per cycle while the alarm side does not stall; the
//   detector state loop closes through the compare and timer logic of each detector.
// Reset: asynchronous, active low; clears both pipeline valids, all detector
//   state and loads the register defaults (offsets 500/300, recovery 5000 ms).
`default_nettype none

module peep_limit_alarm import pla_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	pla_snap_if.sink                  snap,
	pla_alarm_if.source               alarm,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data
);

	// ---------------- configuration registers ----------------
	logic [OffsetW-1:0]  high_offset_q;
	logic [OffsetW-1:0]  low_offset_q;
	logic [RecTimeW-1:0] recovery_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_offset_q   <= HighOffsetReset;
			low_offset_q    <= LowOffsetReset;
			recovery_time_q <= RecoveryTimeReset;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_HIGH_OFFSET:   high_offset_q   <= cfg_data[OffsetW-1:0];
				REG_LOW_OFFSET:    low_offset_q    <= cfg_data[OffsetW-1:0];
				REG_RECOVERY_TIME: recovery_time_q <= cfg_data[RecTimeW-1:0];
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

	// ---------------- stage 1: input register ----------------
	logic      valid_s1;
	snapshot_t snap_s1;
	logic      advance;     // stage 1 word moves into the result register
	logic      out_valid_q;
	alarm_t    out_q;

	// stage 1 drains whenever the result register is empty or being taken
	assign advance    = valid_s1 && (!out_valid_q || alarm.ready);
	assign snap.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (snap.ready) begin
			valid_s1 <= snap.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap.valid && snap.ready) begin
			snap_s1 <= snap.data;
		end
	end

	// ---------------- detectors ----------------
	// State of each detector commits only when its word leaves stage 1,
	// so back-to-back snapshots see the state left by the one before.
	det_cfg_t hi_cfg, lo_cfg;
	logic     hi_alarm, lo_alarm;

	assign hi_cfg = '{offset: high_offset_q, recovery_time: recovery_time_q};
	assign lo_cfg = '{offset: low_offset_q,  recovery_time: recovery_time_q};

	pla_detector u_det_high (
		.clk       (clk),
		.arst_n    (arst_n),
		.high_side (1'b1),
		.advance   (advance),
		.snap      (snap_s1),
		.cfg       (hi_cfg),
		.alarm     (hi_alarm)
	);

	pla_detector u_det_low (
		.clk       (clk),
		.arst_n    (arst_n),
		.high_side (1'b0),
		.advance   (advance),
		.snap      (snap_s1),
		.cfg       (lo_cfg),
		.alarm     (lo_alarm)
	);

	// ---------------- stage 2: result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (alarm.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= '{high_alarm: hi_alarm, low_alarm: lo_alarm};
		end
	end

	assign alarm.valid = out_valid_q;
	assign alarm.data  = out_q;

endmodule

`default_nettype wire

// File: sv/pla_checker.sv
// ----------------------------------------------------------------------------
// pla_checker
// Port-level assertions for peep_limit_alarm, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module pla_checker import pla_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [PhaseW-1:0] in_phase,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              out_high,
	input wire logic              out_low
);

	// stalled alarm word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
		else $error("alarm word changed while stalled");

	// input is only held off by a stalled output
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output side free");

	// a fresh output word comes from a snapshot accepted through the input register
	a_rise_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("alarm word without a matching snapshot");

	// outside inspiration/expiration both alarms are off
	a_other_phase_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && $past(in_valid && in_ready &&
			(in_phase != PHASE_INHALE) && (in_phase != PHASE_EXHALE), 2)
		|-> !out_high && !out_low)
		else $error("alarm set for a snapshot outside ventilation phases");

endmodule

bind peep_limit_alarm pla_checker u_pla_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (snap.valid),
	.in_ready  (snap.ready),
	.in_phase  (snap.data.phase),
	.out_valid (alarm.valid),
	.out_ready (alarm.ready),
	.out_high  (alarm.data.high_alarm),
	.out_low   (alarm.data.low_alarm)
);

`default_nettype wire

// File: dv/pla_checker.sv
// ----------------------------------------------------------------------------
// pla_scoreboard
// Watches the snapshot, alarm and register ports of the PEEP limit alarm,
// predicts both alarm outputs for every accepted snapshot word and compares
// them with the alarm words in order.
// ----------------------------------------------------------------------------
module pla_scoreboard import pla_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	pla_snap_if                  snap,
	pla_alarm_if                 alarm,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	output int                   mismatches,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DetHigh = 0;
	localparam int DetLow  = 1;

	logic [OffsetW-1:0]  high_off;
	logic [OffsetW-1:0]  low_off;
	logic [RecTimeW-1:0] recover_ms;

	logic                alarm_on   [2];
	logic                timing     [2];
	logic                seq_seen   [2];
	logic [SeqW-1:0]     last_seq   [2];
	logic [TimeW-1:0]    rec_start  [2];

	alarm_t              expected_alarms [$];

	task automatic report_mismatch(input string msg);
		$display("%0t: MISMATCH %s", $time, msg);
		mismatches++;
	endtask

	// one detector evaluated on one snapshot; returns its alarm output
	function automatic logic peep_detector_step(input int d, input snapshot_t s);
		int   meas;
		int   lim;
		logic recovered;
		if (s.phase != PHASE_INHALE && s.phase != PHASE_EXHALE) begin
			alarm_on[d]  = 1'b0;
			timing[d]    = 1'b0;
			seq_seen[d]  = 1'b0;
			last_seq[d]  = '0;
			rec_start[d] = '0;
			return 1'b0;
		end
		if (!(s.plan_valid && s.result_complete)) begin
			timing[d] = 1'b0;
			return alarm_on[d];
		end
		meas = int'($signed(s.measured_peep));
		if (d == DetHigh)
			lim = int'($signed(s.set_peep)) + int'(high_off);
		else
			lim = int'($signed(s.set_peep)) - int'(low_off);
		if (s.phase == PHASE_INHALE && s.result_sequence != s.plan_sequence &&
		    (!seq_seen[d] || last_seq[d] != s.plan_sequence)) begin
			last_seq[d] = s.plan_sequence;
			seq_seen[d] = 1'b1;
			if ((d == DetHigh) ? (meas > lim) : (meas < lim)) begin
				alarm_on[d] = 1'b1;
				timing[d]   = 1'b0;
			end
		end
		recovered = (d == DetHigh) ? (meas < lim) : (meas > lim);
		if (!alarm_on[d] || !recovered) begin
			timing[d] = 1'b0;
		end else if (!timing[d]) begin
			rec_start[d] = s.now_ms;
			timing[d]    = 1'b1;
		end else if (TimeW'(s.now_ms - rec_start[d]) >= TimeW'(recover_ms)) begin
			alarm_on[d] = 1'b0;
			timing[d]   = 1'b0;
		end
		return alarm_on[d];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alarm_t predicted;
		alarm_t oldest;
		if (!arst_n) begin
			high_off   = HighOffsetReset;
			low_off    = LowOffsetReset;
			recover_ms = RecoveryTimeReset;
			for (int d = 0; d < 2; d++) begin
				alarm_on[d]  = 1'b0;
				timing[d]    = 1'b0;
				seq_seen[d]  = 1'b0;
				last_seq[d]  = '0;
				rec_start[d] = '0;
			end
			expected_alarms.delete();
			mismatches = 0;
			pending   <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HIGH_OFFSET:   high_off   = cfg_data[OffsetW-1:0];
					REG_LOW_OFFSET:    low_off    = cfg_data[OffsetW-1:0];
					REG_RECOVERY_TIME: recover_ms = cfg_data[RecTimeW-1:0];
					default: ;
				endcase
			end
			if (snap.valid && snap.ready) begin
				predicted.high_alarm = peep_detector_step(DetHigh, snap.data);
				predicted.low_alarm  = peep_detector_step(DetLow, snap.data);
				expected_alarms.push_back(predicted);
			end
			if (alarm.valid && alarm.ready) begin
				if (expected_alarms.size() == 0) begin
					report_mismatch("alarm word with no snapshot waiting");
				end else begin
					oldest = expected_alarms.pop_front();
					if (alarm.data.high_alarm !== oldest.high_alarm)
						report_mismatch($sformatf("high_alarm got %b expected %b",
							alarm.data.high_alarm, oldest.high_alarm));
					if (alarm.data.low_alarm !== oldest.low_alarm)
						report_mismatch($sformatf("low_alarm got %b expected %b",
							alarm.data.low_alarm, oldest.low_alarm));
				end
			end
			pending <= expected_alarms.size();
		end
	end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the PEEP limit alarm: a directed opener, then
// randomized breaths under several register settings, with random gaps on
// both channels and one long alarm-side stall. Checking lives in pla_scoreboard.
// ----------------------------------------------------------------------------
module tb_top import pla_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// phase code 3 is unused by the block; it must behave like "other"
	localparam logic [PhaseW-1:0]   PHASE_UNUSED = 2'd3;
	// register index past the end of the list; writes here are dropped
	localparam logic [CfgIndexW-1:0] REG_NONE    = 2'd3;
	// cycles with no word moving on either channel before we give up
	localparam int QuietLimit   = 1000;
	// alarm words taken before the receiver does its long hold-off
	localparam int StallAfter   = 400;
	localparam int StallCycles  = 120;
	localparam int WordsPerPass = 129;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_data;
	int                   mismatches;
	int                   pending;
	int                   quiet_cycles;

	// stimulus-side copies of what was written, used only to aim the data
	logic [OffsetW-1:0]   cur_high;
	logic [OffsetW-1:0]   cur_low;
	logic [RecTimeW-1:0]  cur_rec;
	logic [TimeW-1:0]     clock_ms;
	logic [SeqW-1:0]      next_seq;
	int                   idle_max;
	int                   sent_words;

	pla_snap_if  snap_ch ();
	pla_alarm_if alarm_ch ();

	always #2ns clk = ~clk;

	peep_limit_alarm DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap      (snap_ch),
		.alarm     (alarm_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pla_scoreboard u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap       (snap_ch),
		.alarm      (alarm_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Offer one snapshot word after a random gap and hold it until taken.
	// Called at a rising edge; valid gets a single update per edge, so a
	// zero gap keeps it high straight across back-to-back words.
	task automatic offer_snapshot(input logic [PhaseW-1:0] ph, input logic pv,
	                              input logic rc, input logic [SeqW-1:0] pseq,
	                              input logic [SeqW-1:0] rseq, input int meas,
	                              input int setp, input logic [TimeW-1:0] now);
		snapshot_t w;
		int        gap;
		w.phase           = ph;
		w.plan_valid      = pv;
		w.result_complete = rc;
		w.plan_sequence   = pseq;
		w.result_sequence = rseq;
		w.measured_peep   = PressW'(meas);
		w.set_peep        = PressW'(setp);
		w.now_ms          = now;
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			snap_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		snap_ch.valid <= 1'b1;
		snap_ch.data  <= w;
		do @(posedge clk); while (!snap_ch.ready);
		sent_words++;
	endtask

	// Drop valid, let every alarm word drain, then write all registers plus
	// one write to the unused index. The block is idle throughout.
	task automatic reconfigure(input logic [CfgDataW-1:0] hi, input logic [CfgDataW-1:0] lo,
	                           input logic [CfgDataW-1:0] rec);
		snap_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HIGH_OFFSET;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= REG_LOW_OFFSET;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_RECOVERY_TIME;
		cfg_data  <= rec;
		@(posedge clk);
		cfg_index <= REG_NONE;
		cfg_data  <= CfgDataW'($urandom);
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_high  = hi[OffsetW-1:0];
		cur_low   = lo[OffsetW-1:0];
		cur_rec   = rec;
	endtask

	// Measured PEEP aimed mostly right at one of the two limits, where the
	// strict compares flip, with some mid-band and some anywhere.
	function automatic int pick_peep(input int setp);
		case ($urandom_range(0, 9))
			0, 1, 2: return setp + int'(cur_high) + int'($urandom_range(0, 4)) - 2;
			3, 4, 5: return setp - int'(cur_low) + int'($urandom_range(0, 4)) - 2;
			6, 7:    return setp + int'($urandom_range(0, 200)) - 100;
			default: return int'($urandom);
		endcase
	endfunction

	// Time moves in steps scaled to the recovery time so alarms both clear
	// and hold; now and then it jumps anywhere, including backwards.
	function automatic logic [TimeW-1:0] next_time();
		if ($urandom_range(0, 49) == 0)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(0, int'(cur_rec) / 2 + 3);
		return clock_ms;
	endfunction

	// One well-formed breath: a few inspiration words carrying a new plan,
	// then expiration words, with the odd invalid or out-of-phase word.
	task automatic run_breath();
		logic [SeqW-1:0] pseq;
		logic [SeqW-1:0] rseq;
		int              setp;
		int              n;
		logic            pv;
		logic            rc;
		if ($urandom_range(0, 9) == 0)
			next_seq = $urandom;
		else
			next_seq = next_seq + 1'b1;
		pseq = next_seq;
		case ($urandom_range(0, 19))
			0, 1:    rseq = pseq;       // result caught up: no new check
			2:       rseq = $urandom;
			default: rseq = pseq - 1'b1;
		endcase
		if ($urandom_range(0, 6) == 0)
			setp = int'($signed(PressW'($urandom)));
		else
			setp = $urandom_range(0, 3000);
		n = $urandom_range(1, 3);
		repeat (n) begin
			pv = 1'b1;
			rc = 1'b1;
			if ($urandom_range(0, 11) == 0) begin
				pv = $urandom;
				rc = $urandom;
			end
			offer_snapshot(PHASE_INHALE, pv, rc, pseq, rseq, pick_peep(setp), setp,
				next_time());
		end
		n = $urandom_range(1, 6);
		repeat (n) begin
			pv = 1'b1;
			rc = 1'b1;
			if ($urandom_range(0, 11) == 0) begin
				pv = $urandom;
				rc = $urandom;
			end
			offer_snapshot(PHASE_EXHALE, pv, rc, pseq, rseq, pick_peep(setp), setp,
				next_time());
		end
		if ($urandom_range(0, 15) == 0)
			offer_snapshot($urandom_range(0, 1) ? PHASE_OTHER : PHASE_UNUSED, 1'b1, 1'b1,
				pseq, rseq, pick_peep(setp), setp, next_time());
	endtask

	// Main stimulus: reset, directed opener, randomized passes, drain, verdict.
	initial begin
		int pass_end;
		arst_n        <= 1'b0;
		snap_ch.valid <= 1'b0;
		snap_ch.data  <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_HIGH_OFFSET;
		cfg_data      <= '0;
		cur_high       = HighOffsetReset;
		cur_low        = LowOffsetReset;
		cur_rec        = RecoveryTimeReset;
		clock_ms       = '0;
		next_seq       = '0;
		idle_max       = 3;
		sent_words     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: high limit set+500, low limit set-300, 5000 ms.
		// Other phase and the unused code both clear and read zero.
		offer_snapshot(PHASE_OTHER, 1, 1, 1, 0, 0, 500, 0);
		offer_snapshot(PHASE_UNUSED, 1, 1, 1, 0, 0, 500, 10);
		// one over the high limit on a new sequence raises the high alarm
		offer_snapshot(PHASE_INHALE, 1, 1, 1, 0, 1001, 500, 100);
		// same sequence again: no recheck; below limit starts recovery
		offer_snapshot(PHASE_INHALE, 1, 1, 1, 0, 999, 500, 200);
		// sitting exactly on the limit is not recovered
		offer_snapshot(PHASE_EXHALE, 1, 1, 1, 0, 1000, 500, 300);
		offer_snapshot(PHASE_EXHALE, 1, 1, 1, 0, 999, 500, 400);
		// invalid plan, then incomplete result: timer dropped, alarm held
		offer_snapshot(PHASE_EXHALE, 0, 1, 1, 0, 999, 500, 10000);
		offer_snapshot(PHASE_EXHALE, 1, 0, 1, 0, 999, 500, 10001);
		// clears exactly when the elapsed time reaches the recovery time
		offer_snapshot(PHASE_EXHALE, 1, 1, 1, 0, 999, 500, 5000);
		offer_snapshot(PHASE_EXHALE, 1, 1, 1, 0, 999, 500, 9999);
		offer_snapshot(PHASE_EXHALE, 1, 1, 1, 0, 999, 500, 10000);
		// result sequence equal to plan: low exceedance is not checked
		offer_snapshot(PHASE_INHALE, 1, 1, 2, 2, 199, 500, 10100);
		// on the low limit is not an exceedance, and the sequence is spent
		offer_snapshot(PHASE_INHALE, 1, 1, 3, 2, 200, 500, 10200);
		offer_snapshot(PHASE_INHALE, 1, 1, 3, 2, 199, 500, 10300);
		// pressure extremes: most negative reading under the top setting
		offer_snapshot(PHASE_INHALE, 1, 1, 16'hFFFF, 3, -32768, 32767, 32'hFFFF_F000);
		offer_snapshot(PHASE_EXHALE, 1, 1, 16'hFFFF, 3, 32767, -32768, 32'hFFFF_F000);
		// recovery across the 32-bit time wrap: 4999 ms holds, 5000 clears
		offer_snapshot(PHASE_EXHALE, 1, 1, 16'hFFFF, 3, 32767, -32768, 32'h0000_0387);
		offer_snapshot(PHASE_EXHALE, 1, 1, 16'hFFFF, 3, 32767, -32768, 32'h0000_0388);
		// top reading under the lowest setting raises the high alarm
		offer_snapshot(PHASE_INHALE, 1, 1, 5, 16'hFFFF, 32767, -32768, 32'h0000_0400);

		// Zero offsets and zero recovery: an alarm clears on the second
		// recovered word, even with no time passing.
		reconfigure(0, 0, 0);
		offer_snapshot(PHASE_INHALE, 1, 1, 6, 5, 101, 100, 500);
		offer_snapshot(PHASE_EXHALE, 1, 1, 6, 5, 99, 100, 500);
		offer_snapshot(PHASE_EXHALE, 1, 1, 6, 5, 99, 100, 500);
		offer_snapshot(PHASE_INHALE, 1, 1, 7, 6, 99, 100, 600);
		offer_snapshot(PHASE_EXHALE, 1, 1, 7, 6, 101, 100, 600);
		offer_snapshot(PHASE_EXHALE, 1, 1, 7, 6, 101, 100, 600);
		next_seq = 16'd8;
		clock_ms = 32'd1000;

		// Randomized passes, each under its own register setting.
		// Passes with idle_max 0 give long stretches with no gaps.
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin
					reconfigure(5000, 5000, 65535);
					idle_max = 3;
				end
				1: begin
					reconfigure($urandom_range(0, 5000), $urandom_range(0, 5000), 0);
					idle_max = 0;
				end
				2: begin
					reconfigure(0, 0, 1);
					idle_max = 3;
				end
				3: begin
					reconfigure($urandom_range(0, 5000), $urandom_range(0, 5000),
						$urandom_range(0, 65535));
					idle_max = 1;
				end
				4: begin
					reconfigure($urandom_range(0, 5000), $urandom_range(0, 5000), 5000);
					idle_max = 0;
				end
				5: begin
					reconfigure($urandom_range(0, 5000), $urandom_range(0, 5000),
						$urandom_range(0, 300));
					idle_max = 3;
					clock_ms = 32'hFFFF_FC00;  // run through the time wrap
				end
				default: begin
					reconfigure(HighOffsetReset, LowOffsetReset, RecoveryTimeReset);
					idle_max = 2;
				end
			endcase
			pass_end = sent_words + WordsPerPass;
			while (sent_words < pass_end) begin
				if ($urandom_range(0, 19) == 0)
					// noise: every field anywhere in its range
					offer_snapshot($urandom_range(0, 3), $urandom, $urandom, $urandom,
						$urandom, int'($urandom), int'($urandom), $urandom);
				else
					run_breath();
			end
		end

		// drain and give the pipe a few more cycles to show stray words
		snap_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Alarm side: random ready gaps per word, plus one long hold-off so the
	// block backs up and stalls the snapshot side while words keep coming.
	initial begin
		int gap;
		int got;
		got = 0;
		alarm_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (got == StallAfter) begin
				alarm_ch.ready <= 1'b0;
				repeat (StallCycles) @(posedge clk);
			end
			gap = $urandom_range(0, idle_max);
			if (gap > 0) begin
				alarm_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			alarm_ch.ready <= 1'b1;
			do @(posedge clk); while (!alarm_ch.valid);
			got++;
		end
	end

	// watchdog: any accepted word on either side resets the count
	always @(posedge clk) begin
		if (!arst_n || (snap_ch.valid && snap_ch.ready) || (alarm_ch.valid && alarm_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("%0t: timeout, no word moved for %0d cycles", $time, QuietLimit);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
